// ----- design/smpq_pkg.sv -----
package smpq_pkg;

	// Actions carried on the input item.
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_SERVE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int TAG_W  = 16;
	localparam int PRIO_W = 8;
	localparam int ARR_W  = 32;
	localparam int OCC_W  = 9;

	// One heap slot as stored in memory.
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
		logic [ARR_W-1:0]  arr;
	} slot_t;

	// True when slot a must be served before slot b.
	function automatic logic ahead(input slot_t a, input slot_t b);
		logic r;
		if (a.prio != b.prio) begin
			r = a.prio > b.prio;
		end else begin
			r = a.arr < b.arr;
		end
		return r;
	endfunction

endpackage

// ----- design/stable_max_priority_queue.sv -----
// Stable max priority queue kept as a binary heap in one synchronous slot memory
// (one write port, one registered read port). Each item raises busy and gives
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall it. A clear, an unused action, a serve on an empty queue, an insert into
// a full queue or an insert into an empty queue goes straight to the result. An
// insert into a non-empty queue rises level by level, up to the root at most. A
// serve that leaves the queue empty returns the root without sinking; any other
// serve moves the last slot to the root and sinks it level by level, reading
// each child that a level has. Each heap step is paced by the single memory
// read port, so the number of steps at full depth grows with log2(CAPACITY).
// No clearing pass is needed after reset.
module stable_max_priority_queue #(
	parameter int CAPACITY = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [smpq_pkg::TAG_W-1:0] entry_tag,
	input  logic [smpq_pkg::PRIO_W-1:0] priority_req,
	output logic                       done,
	output logic [smpq_pkg::TAG_W-1:0] served_tag,
	output logic [smpq_pkg::PRIO_W-1:0] served_priority,
	output logic [1:0]                 status,
	output logic [smpq_pkg::OCC_W-1:0] occupancy
);
	import smpq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DONE  = 4'd1;
	localparam logic [3:0] S_UP_RD = 4'd2;
	localparam logic [3:0] S_UP_WT = 4'd3;
	localparam logic [3:0] S_UP_CM = 4'd4;
	localparam logic [3:0] S_SV_RD = 4'd5;
	localparam logic [3:0] S_SV_WT = 4'd6;
	localparam logic [3:0] S_SV_LT = 4'd7;
	localparam logic [3:0] S_DN_L  = 4'd8;
	localparam logic [3:0] S_DN_R  = 4'd9;
	localparam logic [3:0] S_DN_CM = 4'd10;
	localparam logic [3:0] S_DN_RC = 4'd11;
	localparam logic [3:0] S_DN_WR = 4'd12;

	logic [3:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [ARR_W-1:0]  arr_cnt_q;
	slot_t             cur_q;
	slot_t             best_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     best_idx_q;
	logic [CW:0]       lch_q;
	logic [TAG_W-1:0]  rtag_q;
	logic [PRIO_W-1:0] rprio_q;
	logic [1:0]        rstat_q;
	logic              done_q;

	// Slot memory.
	slot_t             mem [CAPACITY];
	logic              we;
	logic [AW-1:0]     waddr;
	slot_t             wdata;
	logic [AW-1:0]     raddr;
	logic              re;
	slot_t             rdata;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	logic [AW-1:0] parent;
	logic [CW:0]   child_l;
	logic [CW:0]   child_r;
	logic [CW-1:0] last;

	assign parent  = (idx_q - AW'(1)) >> 1;
	assign child_l = (CW+1)'({idx_q, 1'b1});
	assign child_r = child_l + (CW+1)'(1);
	assign last    = count_q - CW'(1);

	// Memory port control per state.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		re    = 1'b0;
		raddr = parent;
		unique case (state_q)
			S_IDLE: begin
				if (start && action == ACT_INSERT && count_q < CAP_C) begin
					we          = 1'b1;
					waddr       = count_q[AW-1:0];
					wdata.tag   = entry_tag;
					wdata.prio  = priority_req;
					wdata.arr   = arr_cnt_q;
				end
				if (start && action == ACT_SERVE && count_q != '0) begin
					re    = 1'b1;
					raddr = '0;
				end
			end
			S_UP_RD: begin
				re    = 1'b1;
				raddr = parent;
			end
			S_UP_CM: begin
				// Swap with the parent when the rising slot is ahead; otherwise the
				// rising slot settles here.
				we    = 1'b1;
				waddr = idx_q;
				if (ahead(cur_q, rdata)) begin
					wdata = rdata;
				end else begin
					wdata = cur_q;
				end
			end
			S_SV_RD: begin
				re    = 1'b1;
				raddr = count_q[AW-1:0];
			end
			S_DN_L: begin
				re    = 1'b1;
				raddr = child_l[AW-1:0];
			end
			S_DN_R: begin
				re    = 1'b1;
				raddr = child_r[AW-1:0];
			end
			S_DN_RC: begin
				// The better child moves up into the sinking slot's place.
				if (best_idx_q != idx_q) begin
					we    = 1'b1;
					waddr = idx_q;
					wdata = best_q;
				end
			end
			S_DN_WR: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = best_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			arr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rtag_q  <= '0;
						rprio_q <= '0;
						rstat_q <= ST_OK;
						state_q <= S_DONE;
						case (action)
							ACT_INSERT: begin
								if (count_q >= CAP_C) begin
									rstat_q <= ST_FULL;
								end else begin
									cur_q.tag  <= entry_tag;
									cur_q.prio <= priority_req;
									cur_q.arr  <= arr_cnt_q;
									idx_q      <= count_q[AW-1:0];
									arr_cnt_q  <= arr_cnt_q + ARR_W'(1);
									count_q    <= count_q + CW'(1);
									state_q    <= (count_q == '0) ? S_DONE : S_UP_RD;
								end
							end
							ACT_SERVE: begin
								if (count_q == '0) begin
									rstat_q <= ST_EMPTY;
								end else begin
									state_q <= S_SV_WT;
								end
							end
							ACT_CLEAR: begin
								count_q   <= '0;
								arr_cnt_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_UP_RD: state_q <= S_UP_WT;
				S_UP_WT: state_q <= S_UP_CM;
				S_UP_CM: begin
					if (ahead(cur_q, rdata)) begin
						idx_q   <= parent;
						state_q <= (parent == '0) ? S_DN_WR : S_UP_RD;
						best_q  <= cur_q;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SV_WT: begin
					state_q <= S_SV_RD;
					count_q <= last;
				end
				S_SV_RD: begin
					// Root arrives now; the last slot arrives next cycle.
					rtag_q  <= rdata.tag;
					rprio_q <= rdata.prio;
					state_q <= (count_q == '0) ? S_DONE : S_SV_LT;
				end
				S_SV_LT: begin
					cur_q   <= rdata;
					best_q  <= rdata;
					idx_q   <= '0;
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					lch_q      <= child_l;
					best_q     <= cur_q;
					best_idx_q <= idx_q;
					if (child_l >= (CW+1)'(count_q)) begin
						state_q <= S_DN_WR;
					end else begin
						state_q <= S_DN_R;
					end
				end
				S_DN_R: begin
					// Left child data is here; compare it with the sinking slot.
					if (ahead(rdata, cur_q)) begin
						best_q     <= rdata;
						best_idx_q <= lch_q[AW-1:0];
					end
					state_q <= (lch_q + (CW+1)'(1) < (CW+1)'(count_q)) ? S_DN_CM : S_DN_RC;
				end
				S_DN_CM: begin
					if (ahead(rdata, best_q)) begin
						best_q     <= rdata;
						best_idx_q <= AW'(lch_q + (CW+1)'(1));
					end
					state_q <= S_DN_RC;
				end
				S_DN_RC: begin
					if (best_idx_q == idx_q) begin
						state_q <= S_DN_WR;
					end else begin
						// Move the better child up and keep sinking.
						state_q <= S_DN_L;
						idx_q   <= best_idx_q;
						best_q  <= cur_q;
					end
				end
				S_DN_WR: state_q <= S_DONE;
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign served_tag      = rtag_q;
	assign served_priority = rprio_q;
	assign status          = rstat_q;
	assign occupancy       = OCC_W'(count_q);

endmodule

// ----- design/smpq_checker.sv -----
module smpq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [8:0] occupancy
);
	import smpq_pkg::*;

	// A transfer always makes the block busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after transfer");

	// A result ends the item.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy with result");

	// A result strobe lasts one cycle.
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");

	// An empty report means no entries are held.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> occupancy == '0) else $error("empty with entries");

endmodule

bind stable_max_priority_queue smpq_checker u_smpq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .status(status), .occupancy(occupancy)
);
